// File: hdl/hsm_pkg.sv
// ----------------------------------------------------------------------------
// hsm_pkg
// Shared types and constants for the hash set membership table.
// ----------------------------------------------------------------------------
package hsm_pkg;

	// default geometry
	localparam int HSM_BUCKETS = 64;
	localparam int HSM_WAYS    = 4;

	// field widths
	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int CFG_W    = 7;
	localparam int COUNT_W  = 9;
	localparam int COUNT_MAX = 511;

	// modulo unit: bits of dividend consumed per cycle, steps per word
	localparam int MOD_BITS_PER_STEP = 8;
	localparam int MOD_STEPS         = VALUE_W / MOD_BITS_PER_STEP;
	localparam int STEP_W            = $clog2(MOD_STEPS);

	// reset value of the modulus register
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// operation codes
	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	// queue between front and back
	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} f_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_READ
	} b_state_t;

endpackage

// File: hdl/hsm_ram.sv
// ----------------------------------------------------------------------------
// hsm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/hsm_queue.sv
// ----------------------------------------------------------------------------
// hsm_queue
// Two-entry queue that decouples the hashing front from the table back end.
// ----------------------------------------------------------------------------
module hsm_queue #(
	parameter int WIDTH = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   wdata,
	input  logic               pop,
	output logic [WIDTH-1:0]   rdata,
	output hsm_pkg::q_stat_t   stat
);

	localparam int PTR_W = $clog2(hsm_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(hsm_pkg::Q_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [hsm_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata      = slot_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNT_W'(hsm_pkg::Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

// File: hdl/hsm_front.sv
// ----------------------------------------------------------------------------
// hsm_front
// Accepts words and computes the bucket: value modulo the modulus in use,
// eight dividend bits per cycle, then queues op, value and bucket.
// ----------------------------------------------------------------------------
module hsm_front #(
	parameter int BUCKETS = hsm_pkg::HSM_BUCKETS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [hsm_pkg::OP_W-1:0]               op,
	input  logic signed [hsm_pkg::VALUE_W-1:0]     value,
	input  logic [hsm_pkg::CFG_W-1:0]              buckets_in_use,
	input  logic                                   clear_busy,
	input  hsm_pkg::q_stat_t                       q_stat,
	output logic                                   q_push,
	output logic [hsm_pkg::OP_W+hsm_pkg::VALUE_W+(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] q_wdata
);

	localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int REM_W = BKT_W + 1;
	localparam logic [hsm_pkg::STEP_W-1:0] STEP_LAST = hsm_pkg::STEP_W'(hsm_pkg::MOD_STEPS - 1);

	hsm_pkg::f_state_t state_q, state_nx;

	logic                           accept;
	logic [REM_W-1:0]               mod_eff;
	logic [REM_W-1:0]               rem_nx;
	logic [hsm_pkg::STEP_W-1:0]     step_q;
	logic [hsm_pkg::OP_W-1:0]       op_q;
	logic [hsm_pkg::VALUE_W-1:0]    val_q;
	logic [hsm_pkg::VALUE_W-1:0]    div_q;
	logic [REM_W-1:0]               mod_q;
	logic [REM_W-1:0]               rem_q;

	// clamp the configured modulus to 1..BUCKETS
	always_comb begin
		if (buckets_in_use == '0) begin
			mod_eff = REM_W'(1);
		end else if (32'(buckets_in_use) > 32'(BUCKETS)) begin
			mod_eff = REM_W'(BUCKETS);
		end else begin
			mod_eff = REM_W'(buckets_in_use);
		end
	end

	// eight restoring-remainder steps per cycle, top dividend bits first
	always_comb begin
		logic [REM_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < hsm_pkg::MOD_BITS_PER_STEP; i++) begin
			r = {r[REM_W-2:0], div_q[hsm_pkg::VALUE_W-1-i]};
			if (r >= mod_q) r = r - mod_q;
		end
		rem_nx = r;
	end

	// handshake outputs
	always_comb begin
		case (state_q)
			hsm_pkg::F_IDLE: in_stall = clear_busy;
			hsm_pkg::F_PUSH: in_stall = clear_busy || q_stat.full;
			default:         in_stall = 1'b1;
		endcase
		q_push = (state_q == hsm_pkg::F_PUSH) && !q_stat.full;
	end

	assign accept  = in_valid && !in_stall;
	assign q_wdata = {op_q, val_q, rem_q[BKT_W-1:0]};

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			hsm_pkg::F_IDLE: begin
				if (accept) state_nx = hsm_pkg::F_DIV;
			end
			hsm_pkg::F_DIV: begin
				if (step_q == STEP_LAST) state_nx = hsm_pkg::F_PUSH;
			end
			hsm_pkg::F_PUSH: begin
				if (!q_stat.full) state_nx = accept ? hsm_pkg::F_DIV : hsm_pkg::F_IDLE;
			end
			default: state_nx = hsm_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsm_pkg::F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) step_q <= '0;
			else if (state_q == hsm_pkg::F_DIV) step_q <= step_q + hsm_pkg::STEP_W'(1);
		end
	end

	// word and division datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			val_q <= $unsigned(value);
			div_q <= $unsigned(value);
			mod_q <= mod_eff;
			rem_q <= '0;
		end else if (state_q == hsm_pkg::F_DIV) begin
			rem_q <= rem_nx;
			div_q <= div_q << hsm_pkg::MOD_BITS_PER_STEP;
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("front pushed into a full queue");

	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == hsm_pkg::F_DIV)
		else $error("accepted word did not start division");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> rem_q < mod_q)
		else $error("bucket index not below modulus");

endmodule

// File: hdl/hsm_back.sv
// ----------------------------------------------------------------------------
// hsm_back
// Reads one bucket row, matches all ways at once, writes the row back when
// it changes and holds the result word. Sweeps the table clear after reset.
// ----------------------------------------------------------------------------
module hsm_back #(
	parameter int BUCKETS = hsm_pkg::HSM_BUCKETS,
	parameter int WAYS    = hsm_pkg::HSM_WAYS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  hsm_pkg::q_stat_t                       q_stat,
	input  logic [hsm_pkg::OP_W+hsm_pkg::VALUE_W+(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] q_rdata,
	output logic                                   q_pop,
	output logic                                   clear_busy,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   was_present,
	output logic                                   bucket_full,
	output logic [hsm_pkg::COUNT_W-1:0]            member_count
);

	localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int VW    = hsm_pkg::VALUE_W;
	localparam int ROW_W = WAYS * (VW + 1);
	localparam int CNT_W = $clog2(BUCKETS * WAYS + 1);

	hsm_pkg::b_state_t state_q, state_nx;

	logic [BKT_W-1:0]          clr_q;
	logic [hsm_pkg::OP_W-1:0]  op_s1;
	logic [VW-1:0]             val_s1;
	logic [BKT_W-1:0]          bkt_s1;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          cnt_nx;
	logic                      out_valid_q;
	logic                      was_present_q;
	logic                      bucket_full_q;
	logic [hsm_pkg::COUNT_W-1:0] member_count_q;

	logic                      ram_we;
	logic [BKT_W-1:0]          ram_waddr;
	logic [ROW_W-1:0]          ram_wdata;
	logic [ROW_W-1:0]          rd_row;
	logic [WAYS-1:0]           vld;
	logic [WAYS-1:0]           match;
	logic [WAYS-1:0]           hit_oh;
	logic [WAYS-1:0]           free_oh;
	logic [WAYS-1:0]           vld_nx;
	logic [WAYS*VW-1:0]        vals_nx;
	logic                      hit;
	logic                      do_ins;
	logic                      do_del;
	logic                      drop;
	logic                      out_free;

	// row store: valid bits on top, one value per way below
	hsm_ram #(
		.WIDTH(ROW_W),
		.DEPTH(BUCKETS)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (q_rdata[BKT_W-1:0]),
		.rdata (rd_row)
	);

	// way match, lowest hit and lowest free way
	always_comb begin
		vld = rd_row[ROW_W-1 -: WAYS];
		for (int w = 0; w < WAYS; w++) begin
			match[w] = vld[w] && (rd_row[w*VW +: VW] == val_s1);
		end
		hit_oh  = match & (~match + WAYS'(1));
		free_oh = ~vld & (vld + WAYS'(1));
		hit     = |match;
		do_ins  = (op_s1 == hsm_pkg::OP_ADD) && !hit && (|free_oh);
		drop    = (op_s1 == hsm_pkg::OP_ADD) && !hit && !(|free_oh);
		do_del  = (op_s1 == hsm_pkg::OP_REMOVE) && hit;
	end

	// updated row
	always_comb begin
		if (do_ins)      vld_nx = vld | free_oh;
		else if (do_del) vld_nx = vld & ~hit_oh;
		else             vld_nx = vld;
		for (int w = 0; w < WAYS; w++) begin
			vals_nx[w*VW +: VW] = (do_ins && free_oh[w]) ? val_s1 : rd_row[w*VW +: VW];
		end
	end

	// member count after this word
	always_comb begin
		cnt_nx = cnt_q;
		if (do_ins) cnt_nx = cnt_q + CNT_W'(1);
		else if (do_del && cnt_q != '0) cnt_nx = cnt_q - CNT_W'(1);
	end

	// control outputs and RAM write port
	always_comb begin
		out_free   = !out_valid_q || !out_stall;
		clear_busy = (state_q == hsm_pkg::B_CLEAR);
		q_pop      = (state_q == hsm_pkg::B_IDLE) && !q_stat.empty && out_free;
		case (state_q)
			hsm_pkg::B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			hsm_pkg::B_READ: begin
				ram_we    = do_ins || do_del;
				ram_waddr = bkt_s1;
				ram_wdata = {vld_nx, vals_nx};
			end
			default: begin
				ram_we    = 1'b0;
				ram_waddr = bkt_s1;
				ram_wdata = {vld_nx, vals_nx};
			end
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			hsm_pkg::B_CLEAR: begin
				if (clr_q == BKT_W'(BUCKETS - 1)) state_nx = hsm_pkg::B_IDLE;
			end
			hsm_pkg::B_IDLE: begin
				if (q_pop) state_nx = hsm_pkg::B_READ;
			end
			hsm_pkg::B_READ: state_nx = hsm_pkg::B_IDLE;
			default:         state_nx = hsm_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hsm_pkg::B_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == hsm_pkg::B_CLEAR) clr_q <= clr_q + BKT_W'(1);
			if (state_q == hsm_pkg::B_READ) begin
				cnt_q       <= cnt_nx;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// popped word and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1  <= q_rdata[hsm_pkg::OP_W+VW+BKT_W-1 -: hsm_pkg::OP_W];
			val_s1 <= q_rdata[VW+BKT_W-1 -: VW];
			bkt_s1 <= q_rdata[BKT_W-1:0];
		end
		if (state_q == hsm_pkg::B_READ) begin
			was_present_q <= hit;
			bucket_full_q <= drop;
			if (32'(cnt_nx) > 32'(hsm_pkg::COUNT_MAX)) begin
				member_count_q <= hsm_pkg::COUNT_W'(hsm_pkg::COUNT_MAX);
			end else begin
				member_count_q <= hsm_pkg::COUNT_W'(cnt_nx);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign was_present  = was_present_q;
	assign bucket_full  = bucket_full_q;
	assign member_count = member_count_q;

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hsm_pkg::B_READ |-> !out_valid_q)
		else $error("result register overwritten");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(BUCKETS * WAYS))
		else $error("member count beyond table size");

	a_full_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(was_present_q && bucket_full_q))
		else $error("dropped add reported as present");

endmodule

// File: hdl/hash_set_membership_table.sv
// ----------------------------------------------------------------------------
// hash_set_membership_table
// Bucketed hash set of 32-bit values: add, remove and contains per word.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  in       | in_valid / in_stall     | op, value
//  out      | out_valid / out_stall   | was_present, bucket_full, member_count
//  cfg      | cfg_wr_en               | cfg_wr_data (buckets in use)
//
//  The front takes a word, runs the modulo steps at eight dividend bits
//  each, then pushes op, value and bucket; the queue push overlaps the
//  next accept. The back takes one word at a time (bucket row read, then
//  match and row write-back) on the single row RAM.
//  After reset the back sweeps every row of the RAM clear; in_stall
//  stays high while the sweep runs.
//  A stalled result holds in the output register while the front and the
//  two-word queue keep taking words until they fill.
// ----------------------------------------------------------------------------
module hash_set_membership_table #(
	parameter int BUCKETS = hsm_pkg::HSM_BUCKETS,
	parameter int WAYS    = hsm_pkg::HSM_WAYS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [hsm_pkg::CFG_W-1:0]          cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [hsm_pkg::OP_W-1:0]           op,
	input  logic signed [hsm_pkg::VALUE_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               was_present,
	output logic                               bucket_full,
	output logic [hsm_pkg::COUNT_W-1:0]        member_count
);

	localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int QW    = hsm_pkg::OP_W + hsm_pkg::VALUE_W + BKT_W;

	logic [hsm_pkg::CFG_W-1:0] buckets_in_use_q;
	logic                      q_push;
	logic                      q_pop;
	logic [QW-1:0]             q_wdata;
	logic [QW-1:0]             q_rdata;
	hsm_pkg::q_stat_t          q_stat;
	logic                      clear_busy;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buckets_in_use_q <= hsm_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			buckets_in_use_q <= cfg_wr_data;
		end
	end

	hsm_front #(
		.BUCKETS(BUCKETS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.value          (value),
		.buckets_in_use (buckets_in_use_q),
		.clear_busy     (clear_busy),
		.q_stat         (q_stat),
		.q_push         (q_push),
		.q_wdata        (q_wdata)
	);

	hsm_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	hsm_back #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.q_rdata      (q_rdata),
		.q_pop        (q_pop),
		.clear_busy   (clear_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.was_present  (was_present),
		.bucket_full  (bucket_full),
		.member_count (member_count)
	);

endmodule

// File: tb/sv/tb_hash_set_membership_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_set_membership_table
// Self-checking bench for the bucketed hash set: a directed opening covers
// empty queries, duplicate adds, full buckets, lowest-free-way reuse, unused
// op codes and odd moduli; then random add/remove/query traffic runs over
// several bucket counts and idle patterns, with one long receiver hold-off.
// Every accepted word is predicted at acceptance and each result word is
// checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_hash_set_membership_table;

	localparam int BUCKETS      = hsm_pkg::HSM_BUCKETS;
	localparam int WAYS         = hsm_pkg::HSM_WAYS;
	localparam int ENTRIES      = BUCKETS * WAYS;
	localparam int POOL_SIZE    = 40;
	localparam int PHASE_ITEMS  = 200;
	localparam int PHASES       = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 8;
	localparam int TIMEOUT_NS   = 5_000_000;
	localparam int REPORT_LIMIT = 10;

	// op 3 is not decoded by the block; it behaves as a query
	localparam logic [hsm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [hsm_pkg::OP_W-1:0]    op;
		logic [hsm_pkg::VALUE_W-1:0] value;
	} set_request_t;

	typedef struct packed {
		logic                        was_present;
		logic                        bucket_full;
		logic [hsm_pkg::COUNT_W-1:0] member_count;
	} set_result_t;

	// DUT connections
	logic                               clk          = 1'b0;
	logic                               arst_n       = 1'b0;
	logic                               cfg_wr_en    = 1'b0;
	logic [hsm_pkg::CFG_W-1:0]          cfg_wr_data  = '0;
	logic                               in_valid     = 1'b0;
	logic                               in_stall;
	logic [hsm_pkg::OP_W-1:0]           in_op        = '0;
	logic signed [hsm_pkg::VALUE_W-1:0] in_value     = '0;
	logic                               out_valid;
	logic                               out_stall    = 1'b0;
	logic                               was_present;
	logic                               bucket_full;
	logic [hsm_pkg::COUNT_W-1:0]        member_count;

	// shadow copy of the set
	logic [hsm_pkg::VALUE_W-1:0] shadow_value [ENTRIES];
	bit                          shadow_valid [ENTRIES];
	int unsigned                 shadow_count = 0;
	logic [hsm_pkg::CFG_W-1:0]   shadow_buckets = hsm_pkg::CFG_RESET;

	set_request_t pending_requests [$];
	set_result_t  awaited_results  [$];
	logic [hsm_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	bit  pressure_go    = 1'b0;
	logic long_hold     = 1'b0;

	int pushed_total   = 0;
	int accepted_total = 0;
	int results_seen   = 0;
	int present_hits   = 0;
	int full_drops     = 0;
	int cfg_writes     = 0;
	int mismatches     = 0;

	hash_set_membership_table #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (in_op),
		.value       (in_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.was_present (was_present),
		.bucket_full (bucket_full),
		.member_count(member_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// zero acts as one, anything above the bucket count is clamped
	function automatic int unsigned effective_mod();
		int unsigned m;
		m = 32'(shadow_buckets);
		if (m == 0) m = 1;
		if (m > BUCKETS) m = BUCKETS;
		return m;
	endfunction

	// apply one word to the shadow set, return the result it must produce
	function automatic set_result_t apply_request(set_request_t req);
		int unsigned base;
		int          hit;
		int          free_way;
		int          w;
		set_result_t res;
		base     = (req.value % effective_mod()) * WAYS;
		hit      = -1;
		free_way = -1;
		for (w = 0; w < WAYS; w++) begin
			if (shadow_valid[base + w]) begin
				if (hit < 0 && shadow_value[base + w] == req.value) hit = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		res.bucket_full = 1'b0;
		if (req.op == hsm_pkg::OP_ADD) begin
			if (hit < 0) begin
				if (free_way < 0) begin
					res.bucket_full = 1'b1;
				end else begin
					shadow_value[base + free_way] = req.value;
					shadow_valid[base + free_way] = 1'b1;
					shadow_count++;
				end
			end
		end else if (req.op == hsm_pkg::OP_REMOVE) begin
			if (hit >= 0) begin
				shadow_valid[base + hit] = 1'b0;
				if (shadow_count > 0) shadow_count--;
			end
		end
		res.was_present  = (hit >= 0);
		res.member_count = (shadow_count > hsm_pkg::COUNT_MAX)
			? hsm_pkg::COUNT_W'(hsm_pkg::COUNT_MAX)
			: hsm_pkg::COUNT_W'(shadow_count);
		return res;
	endfunction

	// request driver: predict on acceptance, then offer the next word or idle
	always @(posedge clk) begin : request_driver
		set_request_t cur_req;
		set_request_t next_req;
		logic         taken;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			taken = in_valid && !in_stall;
			if (taken) begin
				cur_req.op    = in_op;
				cur_req.value = in_value;
				awaited_results.push_back(apply_request(cur_req));
				accepted_total++;
			end
			// a stalled word stays as it is
			if (!in_valid || taken) begin
				if (pending_requests.size() != 0 &&
				    $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = pending_requests.pop_front();
					in_valid <= 1'b1;
					in_op    <= next_req.op;
					in_value <= next_req.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin : result_monitor
		set_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= long_hold || ($urandom_range(0, 99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected result word: present=%0b full=%0b count=%0d",
							was_present, bucket_full, member_count);
				end else begin
					want = awaited_results.pop_front();
					if (want.was_present) present_hits++;
					if (want.bucket_full) full_drops++;
					if (was_present !== want.was_present ||
					    bucket_full !== want.bucket_full ||
					    member_count !== want.member_count) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$write("result %0d: expected present=%0b full=%0b count=%0d,",
								results_seen, want.was_present, want.bucket_full,
								want.member_count);
							$display(" got present=%0b full=%0b count=%0d",
								was_present, bucket_full, member_count);
						end
					end
				end
			end
		end
	end

	// long receiver hold-off, so the block backs up and stalls its input
	initial begin : receiver_hold_off
		wait (pressure_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic push_item(input logic [hsm_pkg::OP_W-1:0] op_code,
		input logic [hsm_pkg::VALUE_W-1:0] val);
		set_request_t req;
		req.op    = op_code;
		req.value = val;
		pending_requests.push_back(req);
		pushed_total++;
	endtask

	// wait until every word is accepted and answered, then let the block settle
	task automatic drain();
		while (accepted_total != pushed_total || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_buckets(input logic [hsm_pkg::CFG_W-1:0] setting);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= setting;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_buckets = setting;
		cfg_writes++;
	endtask

	// values often collide in a few buckets or repeat, so adds hit, fill and drop
	function automatic logic [hsm_pkg::VALUE_W-1:0] pick_value();
		int unsigned                 sel;
		logic [hsm_pkg::VALUE_W-1:0] v;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			v = $urandom_range(0, 31) * effective_mod() + $urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0) v[hsm_pkg::VALUE_W-1] = 1'b1;
		end else if (sel < 80) begin
			v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	function automatic logic [hsm_pkg::OP_W-1:0] pick_op();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 45) return hsm_pkg::OP_ADD;
		if (sel < 70) return hsm_pkg::OP_REMOVE;
		if (sel < 95) return hsm_pkg::OP_QUERY;
		return OP_UNUSED;
	endfunction

	task automatic random_items(input int count);
		int i;
		for (i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
		for (i = 0; i < count; i++) push_item(pick_op(), pick_value());
	endtask

	// main sequence
	initial begin : stimulus
		logic [hsm_pkg::CFG_W-1:0] phase_cfg [PHASES];
		int p;
		for (p = 0; p < ENTRIES; p++) begin
			shadow_valid[p] = 1'b0;
			shadow_value[p] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset modulus: bucket 0 filled, then one more add dropped
		push_item(hsm_pkg::OP_QUERY,  32'd0);
		push_item(hsm_pkg::OP_ADD,    32'd0);
		push_item(hsm_pkg::OP_ADD,    32'd0);
		push_item(hsm_pkg::OP_ADD,    32'd64);
		push_item(hsm_pkg::OP_ADD,    32'd128);
		push_item(hsm_pkg::OP_ADD,    32'd192);
		push_item(hsm_pkg::OP_ADD,    32'd256);
		// sign bit set: bucket from the unsigned pattern
		push_item(hsm_pkg::OP_ADD,    32'h8000_0001);
		push_item(hsm_pkg::OP_ADD,    32'hFFFF_FFFF);
		push_item(hsm_pkg::OP_ADD,    32'h7FFF_FFFF);
		push_item(hsm_pkg::OP_QUERY,  32'd64);
		push_item(OP_UNUSED,          32'd128);
		push_item(hsm_pkg::OP_REMOVE, 32'd64);
		push_item(hsm_pkg::OP_REMOVE, 32'd64);
		// freed way 1 is the lowest free one
		push_item(hsm_pkg::OP_ADD,    32'd256);
		push_item(hsm_pkg::OP_QUERY,  32'h8000_0001);
		push_item(OP_UNUSED,          32'h1234_5678);
		drain();

		// modulus zero: everything lands in the full bucket 0
		write_buckets(7'd0);
		push_item(hsm_pkg::OP_ADD,    32'd5);
		push_item(hsm_pkg::OP_QUERY,  32'd256);
		push_item(hsm_pkg::OP_REMOVE, 32'd0);
		push_item(hsm_pkg::OP_ADD,    32'd5);
		drain();

		// oversized modulus clamps; the value 5 is now out of reach but counted
		write_buckets(7'd127);
		push_item(hsm_pkg::OP_QUERY,  32'hFFFF_FFFF);
		push_item(hsm_pkg::OP_QUERY,  32'd5);
		drain();
		write_buckets(7'd7);
		push_item(hsm_pkg::OP_QUERY,  32'd64);
		push_item(hsm_pkg::OP_ADD,    32'h8000_0001);
		drain();

		// back-pressure: sender flat out while the receiver holds off
		write_buckets(hsm_pkg::CFG_RESET);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		pressure_go    = 1'b1;
		random_items(80);
		drain();

		// random phases over several bucket counts and idle patterns
		phase_cfg[0] = 7'd1;
		phase_cfg[1] = 7'd64;
		phase_cfg[2] = 7'd127;
		phase_cfg[3] = 7'd0;
		phase_cfg[4] = 7'd7;
		phase_cfg[5] = 7'd33;
		phase_cfg[6] = 7'd65;
		phase_cfg[7] = hsm_pkg::CFG_W'($urandom_range(2, 63));
		for (p = 0; p < PHASES; p++) begin
			write_buckets(phase_cfg[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			random_items(PHASE_ITEMS);
			drain();
		end

		repeat (20) @(posedge clk);
		if (awaited_results.size() != 0) mismatches++;
		$display("covered %0d words over %0d bucket settings: %0d hits, %0d dropped adds",
			accepted_total, cfg_writes, present_hits, full_drops);
		$display("checked %0d result words, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: hash_set_membership_table.f
hdl/hsm_pkg.sv
hdl/hsm_ram.sv
hdl/hsm_queue.sv
hdl/hsm_front.sv
hdl/hsm_back.sv
hdl/hash_set_membership_table.sv
tb/sv/tb_hash_set_membership_table.sv
